// ----- hw/rtl/lzbd_pkg.sv -----
// lzbd_pkg: shared types, decode phases and flag-bit decode function
// for the lzss bit-flag decompressor; no dependencies
package lzbd_pkg;

	typedef enum logic [5:0] {
		PH_TOP   = 6'd1,
		PH_KIND  = 6'd2,
		PH_L1    = 6'd3,
		PH_L2    = 6'd4,
		PH_L3    = 6'd5,
		PH_L4    = 6'd6,
		PH_L5    = 6'd7,
		PH_L6    = 6'd8,
		PH_L7    = 6'd9,
		PH_L8    = 6'd10,
		PH_N1    = 6'd11,
		PH_N2    = 6'd12,
		PH_N3    = 6'd13,
		PH_N4    = 6'd14,
		PH_N5    = 6'd15,
		PH_N6    = 6'd16,
		PH_N7    = 6'd17,
		PH_N8    = 6'd18,
		PH_N9    = 6'd19,
		PH_N10   = 6'd20,
		PH_S1    = 6'd21,
		PH_SEND  = 6'd22,
		PH_S2    = 6'd23,
		PH_S3    = 6'd24,
		PH_S4    = 6'd25,
		PH_LIT   = 6'd32,
		PH_LBYTE = 6'd33,
		PH_SBYTE = 6'd34,
		PH_NBYTE = 6'd35,
		PH_DONE  = 6'd36
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BITS,
		ST_RD,
		ST_WR,
		ST_END
	} state_t;

	localparam int DIST_W = 14;
	localparam int LEN_W  = 12;
	localparam int CNT_W  = 9;

	typedef struct packed {
		logic accept;
		logic bit_step;
		logic wr_step;
		logic end_load;
	} cmd_t;

	typedef struct packed {
		logic lit_go;
		logic copy_go;
		logic bit_go;
		logic copy_now;
		logic end_now;
		logic cnt_last;
		logic emit_need;
		logic out_free;
	} stat_t;

	typedef struct packed {
		phase_t              ph;
		logic [DIST_W-1:0]   span;
		logic [LEN_W-1:0]    len;
		logic                copy;
		logic [CNT_W-1:0]    clen;
		logic                ended;
	} bit_res_t;

	function automatic bit_res_t take_bit(phase_t ph, logic [DIST_W-1:0] span,
			logic [LEN_W-1:0] len, logic b);
		bit_res_t r;
		r.ph    = ph;
		r.span  = span;
		r.len   = len;
		r.copy  = 1'b0;
		r.clen  = CNT_W'(2);
		r.ended = 1'b0;
		unique case (ph)
			PH_TOP:  r.ph = b ? PH_LIT : PH_KIND;
			PH_KIND: r.ph = b ? PH_LBYTE : PH_SBYTE;
			PH_L1: begin
				if (!b) r.len = len + LEN_W'(256);
				r.ph = PH_L2;
			end
			PH_L2, PH_L3, PH_L5, PH_L7: begin
				if (b) begin
					r.span = span + DIST_W'(len);
					r.len  = '0;
					r.ph   = PH_N1;
				end else begin
					unique case (ph)
						PH_L2: begin
							r.span = span + DIST_W'(512);
							r.ph   = PH_L3;
						end
						PH_L3: begin
							r.len = len << 1;
							r.ph  = PH_L4;
						end
						PH_L5: begin
							r.len = len << 1;
							r.ph  = PH_L6;
						end
						default: begin
							r.span = span + DIST_W'(2048);
							r.len  = len << 1;
							r.ph   = PH_L8;
						end
					endcase
				end
			end
			PH_L4: begin
				if (!b) r.len = len + LEN_W'(256);
				r.span = span + DIST_W'(512);
				r.ph   = PH_L5;
			end
			PH_L6: begin
				if (!b) r.len = len + LEN_W'(256);
				r.span = span + DIST_W'(1024);
				r.ph   = PH_L7;
			end
			PH_L8: begin
				r.span = span + DIST_W'(b ? len : len + LEN_W'(256));
				r.len  = '0;
				r.ph   = PH_N1;
			end
			PH_N1, PH_N2, PH_N3, PH_N4: begin
				if (b) begin
					r.copy = 1'b1;
					r.clen = CNT_W'(ph - PH_N1) + CNT_W'(3);
					r.ph   = PH_TOP;
				end else begin
					r.ph = phase_t'(ph + 6'd1);
				end
			end
			PH_N5: r.ph = b ? PH_N6 : PH_N7;
			PH_N6: begin
				r.copy = 1'b1;
				r.clen = b ? CNT_W'(8) : CNT_W'(7);
				r.ph   = PH_TOP;
			end
			PH_N7: begin
				if (b) r.ph = PH_NBYTE;
				else begin
					r.len = LEN_W'(9);
					r.ph  = PH_N8;
				end
			end
			PH_N8: begin
				if (b) r.len = len + LEN_W'(4);
				r.ph = PH_N9;
			end
			PH_N9: begin
				if (b) r.len = len + LEN_W'(2);
				r.ph = PH_N10;
			end
			PH_N10: begin
				r.len  = len + LEN_W'(b);
				r.copy = 1'b1;
				r.clen = len[CNT_W-1:0] + CNT_W'(b);
				r.ph   = PH_TOP;
			end
			PH_S1: begin
				if (!b) begin
					if (span != DIST_W'(1)) begin
						r.copy = 1'b1;
						r.ph   = PH_TOP;
					end else begin
						r.ph = PH_SEND;
					end
				end else begin
					r.span = span + DIST_W'(256);
					r.ph   = PH_S2;
				end
			end
			PH_SEND: begin
				if (!b) begin
					r.ph    = PH_DONE;
					r.ended = 1'b1;
				end else begin
					r.ph = PH_TOP;
				end
			end
			PH_S2: begin
				if (!b) r.span = span + DIST_W'(1024);
				r.ph = PH_S3;
			end
			PH_S3: begin
				if (!b) r.span = span + DIST_W'(512);
				r.ph = PH_S4;
			end
			PH_S4: begin
				if (!b) r.span = span + DIST_W'(256);
				r.copy = 1'b1;
				r.ph   = PH_TOP;
			end
			default: r.ph = ph;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/lzbd_if.sv -----
// lzbd_if: valid/ready channels for compressed input and decoded output
// no package dependency
interface lzbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_start;

	modport source (output valid, in_byte, stream_start, input ready);
	modport sink (input valid, in_byte, stream_start, output ready);
endinterface

interface lzbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        run_last;
	logic        stream_end;

	modport source (output valid, out_bytes, byte_count, run_last, stream_end, input ready);
	modport sink (input valid, out_bytes, byte_count, run_last, stream_end, output ready);
endinterface

// ----- hw/rtl/lzbd_ram.sv -----
// lzbd_ram: generic single-write, single-read ram with registered read
// no package dependency
module lzbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/lzbd_ctrl.sv -----
// lzbd_ctrl: sequencer for byte intake, flag-bit steps and history copies
// depends on lzbd_pkg
module lzbd_ctrl
	import lzbd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.lit_go) state_d = ST_WR;
					else if (stat.copy_go) state_d = ST_RD;
					else state_d = ST_BITS;
				end
			end
			ST_BITS: begin
				if (!stat.bit_go) state_d = ST_IDLE;
				else if (stat.copy_now) state_d = ST_RD;
				else if (stat.end_now) state_d = ST_END;
			end
			ST_RD: state_d = ST_WR;
			ST_WR: begin
				if (!stat.emit_need || stat.out_free)
					state_d = stat.cnt_last ? ST_BITS : ST_RD;
			end
			ST_END: begin
				if (stat.out_free) state_d = ST_BITS;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.bit_step = (state_q == ST_BITS) && stat.bit_go;
		cmd.wr_step  = (state_q == ST_WR) && (!stat.emit_need || stat.out_free);
		cmd.end_load = (state_q == ST_END) && stat.out_free;
	end

`ifndef SYNTHESIS
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.bit_step, cmd.wr_step, cmd.end_load}))
		else $error("more than one datapath action in a cycle");
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_WR)
		else $error("history read not followed by write");
	a_end_after_bit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_END) |-> $past(cmd.bit_step))
		else $error("end marker without flag bit");
`endif
endmodule

// ----- hw/rtl/lzbd_dp.sv -----
// lzbd_dp: decode registers, history ram, byte packing and output register
// depends on lzbd_pkg and lzbd_ram
module lzbd_dp
	import lzbd_pkg::*;
#(
	parameter int WINDOW_BYTES = 8192,
	parameter int OUT_LANES    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [7:0]  in_byte,
	input  logic        stream_start,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        run_last,
	output logic        stream_end
);
	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int DW = (AW > DIST_W) ? AW : DIST_W;

	logic [AW-1:0]     wp_q;
	logic [15:0]       flag_q;
	logic [7:0]        low_q;
	logic [4:0]        bits_q;
	logic              lrdy_q;
	phase_t            ph_q;
	logic [DIST_W-1:0] dist_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              is_lit_q;
	logic [7:0]        lit_q;
	logic [63:0]       acc_q;
	logic [3:0]        lane_q;
	logic              ovld_q;
	logic [63:0]       odata_q;
	logic [3:0]        ocnt_q;
	logic              olast_q;
	logic              oend_q;

	logic [DW-1:0]     src_x;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic [7:0]        wbyte;
	logic [63:0]       acc_n;
	bit_res_t          br;
	phase_t            ph_e;
	logic [4:0]        bits_e;
	logic              lrdy_e;
	logic              out_free;
	logic              emit_need;

	assign src_x = DW'(wp_q) - DW'(dist_q);
	assign raddr = src_x[AW-1:0];
	assign wbyte = is_lit_q ? lit_q : rdata;
	assign acc_n = acc_q | (64'(wbyte) << {lane_q[2:0], 3'b000});
	assign br    = take_bit(ph_q, dist_q, len_q, flag_q[0]);

	assign ph_e   = stream_start ? PH_TOP : ph_q;
	assign bits_e = stream_start ? 5'd0 : bits_q;
	assign lrdy_e = stream_start ? 1'b0 : lrdy_q;

	assign out_free  = !ovld_q || out_ready;
	assign emit_need = (lane_q + 4'd1 == 4'(OUT_LANES)) || (cnt_q == CNT_W'(1));

	always_comb begin
		stat.lit_go    = !stream_start && bits_q != 5'd0 && ph_q == PH_LIT;
		stat.copy_go   = !stream_start && bits_q != 5'd0 && ph_q == PH_NBYTE;
		stat.bit_go    = bits_q != 5'd0 && ph_q < PH_LIT;
		stat.copy_now  = br.copy;
		stat.end_now   = br.ended;
		stat.cnt_last  = cnt_q == CNT_W'(1);
		stat.emit_need = emit_need;
		stat.out_free  = out_free;
	end

	lzbd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk   (clk),
		.we    (cmd.wr_step),
		.waddr (wp_q),
		.wdata (wbyte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			flag_q   <= '0;
			low_q    <= '0;
			bits_q   <= '0;
			lrdy_q   <= 1'b0;
			ph_q     <= PH_TOP;
			dist_q   <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			is_lit_q <= 1'b0;
			acc_q    <= '0;
			lane_q   <= '0;
			ovld_q   <= 1'b0;
		end else begin
			if (ovld_q && out_ready) ovld_q <= 1'b0;
			if (cmd.accept) begin
				if (stream_start) begin
					wp_q   <= '0;
					flag_q <= '0;
					dist_q <= '0;
					len_q  <= '0;
				end
				bits_q <= bits_e;
				lrdy_q <= lrdy_e;
				ph_q   <= ph_e;
				if (ph_e != PH_DONE) begin
					if (bits_e == 5'd0) begin
						if (!lrdy_e) begin
							low_q  <= in_byte;
							lrdy_q <= 1'b1;
						end else begin
							flag_q <= {in_byte, low_q};
							bits_q <= 5'd16;
							lrdy_q <= 1'b0;
						end
					end else begin
						case (ph_e)
							PH_LIT: begin
								lit_q    <= in_byte;
								cnt_q    <= CNT_W'(1);
								is_lit_q <= 1'b1;
								ph_q     <= PH_TOP;
							end
							PH_LBYTE: begin
								dist_q <= DIST_W'(256) - DIST_W'(in_byte);
								len_q  <= '0;
								ph_q   <= PH_L1;
							end
							PH_SBYTE: begin
								dist_q <= DIST_W'(256) - DIST_W'(in_byte);
								ph_q   <= PH_S1;
							end
							PH_NBYTE: begin
								len_q    <= LEN_W'(in_byte) + LEN_W'(17);
								cnt_q    <= CNT_W'(in_byte) + CNT_W'(17);
								is_lit_q <= 1'b0;
								ph_q     <= PH_TOP;
							end
							default: ;
						endcase
					end
				end
			end
			if (cmd.bit_step) begin
				flag_q <= flag_q >> 1;
				bits_q <= bits_q - 5'd1;
				ph_q   <= br.ph;
				dist_q <= br.span;
				len_q  <= br.len;
				if (br.copy) begin
					cnt_q    <= br.clen;
					is_lit_q <= 1'b0;
				end
			end
			if (cmd.wr_step) begin
				wp_q  <= wp_q + AW'(1);
				cnt_q <= cnt_q - CNT_W'(1);
				if (emit_need) begin
					acc_q   <= '0;
					lane_q  <= '0;
					ovld_q  <= 1'b1;
					odata_q <= acc_n;
					ocnt_q  <= lane_q + 4'd1;
					olast_q <= cnt_q == CNT_W'(1);
					oend_q  <= 1'b0;
				end else begin
					acc_q  <= acc_n;
					lane_q <= lane_q + 4'd1;
				end
			end
			if (cmd.end_load) begin
				ovld_q  <= 1'b1;
				odata_q <= '0;
				ocnt_q  <= '0;
				olast_q <= 1'b1;
				oend_q  <= 1'b1;
			end
		end
	end

	assign out_valid  = ovld_q;
	assign out_bytes  = odata_q;
	assign byte_count = ocnt_q;
	assign run_last   = olast_q;
	assign stream_end = oend_q;

`ifndef SYNTHESIS
	a_wr_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_step |-> cnt_q != '0)
		else $error("history write with no bytes left to copy");
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		lane_q < 4'(OUT_LANES))
		else $error("packing lane out of range");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_step && emit_need) || cmd.end_load |-> out_free)
		else $error("output register overwritten");
`endif
endmodule

// ----- hw/rtl/lzbd_top.sv -----
// lzss_bitflag_decompressor: takes a byte, then consumes flag bits, writes a literal, or
// copies history bytes (each a history read, then a write), or emits the end beat
// a new input byte is taken only after this work and any wait on the output register
// reset clears decode state but lit_q, and the output valid flag; history ram is not cleared
// top level; depends on lzbd_pkg, lzbd_if, lzbd_ctrl, lzbd_dp
module lzss_bitflag_decompressor
	import lzbd_pkg::*;
#(
	parameter int WINDOW_BYTES = 8192,
	parameter int OUT_LANES    = 8
) (
	input logic        clk,
	input logic        arst_n,
	lzbd_in_if.sink    in_ch,
	lzbd_out_if.source out_ch
);
	cmd_t  cmd;
	stat_t stat;

	lzbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzbd_dp #(.WINDOW_BYTES(WINDOW_BYTES), .OUT_LANES(OUT_LANES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_byte      (in_ch.in_byte),
		.stream_start (in_ch.stream_start),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.out_bytes    (out_ch.out_bytes),
		.byte_count   (out_ch.byte_count),
		.run_last     (out_ch.run_last),
		.stream_end   (out_ch.stream_end)
	);
endmodule
